FILE: hdl/iat_pkg.sv
// Package for the indexed array table: sizes, payload types, operation and
// status codes, and the controller state type.
// No dependencies; every other file in hdl/ uses it.
package iat_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int WORD_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 9;
  localparam int ST_W     = 2;
  localparam int AT_W     = 8;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT_AT     = 3'd0,
    OP_PUSH_BACK     = 3'd1,
    OP_GET           = 3'd2,
    OP_REMOVE        = 3'd3,
    OP_POP_BACK      = 3'd4,
    OP_LINEAR_SEARCH = 3'd5,
    OP_BINARY_SEARCH = 3'd6
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_MISS  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_GET,
    S_GET_WAIT,
    S_LINEAR,
    S_BIN_PROBE,
    S_BIN_CMP,
    S_EMIT
  } state_e;

endpackage

FILE: hdl/iat_intf.sv
// Handshake channels of the indexed array table: one request word in, one
// response word out, each with valid/ready.
// Depends on iat_pkg for field widths.
interface iat_in_if;
  logic                       valid;
  logic                       ready;
  logic [iat_pkg::OP_W-1:0]   opcode;
  logic [iat_pkg::POS_W-1:0]  position;
  logic [iat_pkg::WORD_W-1:0] word_in;

  modport source (output valid, output opcode, output position, output word_in,
                  input ready);
  modport sink   (input valid, input opcode, input position, input word_in,
                  output ready);
endinterface

interface iat_out_if;
  logic                       valid;
  logic                       ready;
  logic [iat_pkg::ST_W-1:0]   status;
  logic [iat_pkg::WORD_W-1:0] word_out;
  logic [iat_pkg::AT_W-1:0]   found_at;
  logic [iat_pkg::CNT_W-1:0]  count;

  modport source (output valid, output status, output word_out, output found_at,
                  output count, input ready);
  modport sink   (input valid, input status, input word_out, input found_at,
                  input count, output ready);
endinterface

FILE: hdl/indexed_array_table_unit.sv
// Indexed array table: element store in one synchronous RAM, fill count and
// sequencer in flops. One request at a time; response held in an output register.
// Depends on iat_pkg and the channel interfaces in iat_intf.sv.
//
// Operation time depends on the fill count n and the position p: insert,
// remove and pop_back shift the elements above p one place, one element per
// cycle, through the store's read and write ports; get reads one word; linear
// search walks from index 0 until a hit or the end; binary search alternates
// probe and compare states; errors and unused opcodes go straight to the response
// state; a response also waits in S_EMIT until the output register is free.
// The next request is accepted only after the response is registered.
// Reset: fill count cleared to zero; store contents undefined, no clearing pass.
module indexed_array_table_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  iat_in_if.sink          in_i,
  iat_out_if.source       out_o
);

  iat_pkg::state_e  state_q, state_d;
  iat_pkg::cnt_t    cnt_q, cnt_d;
  iat_pkg::cnt_t    pos_q, pos_d;
  iat_pkg::cnt_t    idx_q, idx_d;     // walk index, also low bound of binary search
  iat_pkg::cnt_t    hi_q, hi_d;
  iat_pkg::word_t   key_q, key_d;
  logic             pend_q, pend_d;   // a RAM read is in flight
  logic             first_q, first_d; // in-flight read is the removed element
  iat_pkg::addr_t   tag_q, tag_d;     // target or index of the in-flight read

  iat_pkg::status_e res_status_q, res_status_d;
  iat_pkg::word_t   res_word_q, res_word_d;
  iat_pkg::addr_t   res_at_q, res_at_d;

  logic             out_vld_q, out_vld_d;
  iat_pkg::status_e out_status_q, out_status_d;
  iat_pkg::word_t   out_word_q, out_word_d;
  iat_pkg::addr_t   out_at_q, out_at_d;
  iat_pkg::cnt_t    out_cnt_q, out_cnt_d;

  iat_pkg::word_t   store_q [iat_pkg::CAPACITY];
  iat_pkg::word_t   rdata_q;
  logic             mem_we;
  iat_pkg::addr_t   mem_waddr;
  iat_pkg::word_t   mem_wdata;
  iat_pkg::addr_t   mem_raddr;

  iat_pkg::cnt_t    mid;
  iat_pkg::cnt_t    in_pos;
  logic             in_acc;

  assign in_i.ready     = (state_q == iat_pkg::S_IDLE);
  assign in_acc         = in_i.valid && in_i.ready;
  assign in_pos         = iat_pkg::CNT_W'(in_i.position);
  assign mid            = idx_q + ((hi_q - idx_q) >> 1);

  assign out_o.valid    = out_vld_q;
  assign out_o.status   = out_status_q;
  assign out_o.word_out = out_word_q;
  assign out_o.found_at = iat_pkg::AT_W'(out_at_q);
  assign out_o.count    = out_cnt_q;

  // element store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= store_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= iat_pkg::S_IDLE;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    hi_q         <= hi_d;
    key_q        <= key_d;
    first_q      <= first_d;
    tag_q        <= tag_d;
    res_status_q <= res_status_d;
    res_word_q   <= res_word_d;
    res_at_q     <= res_at_d;
    out_status_q <= out_status_d;
    out_word_q   <= out_word_d;
    out_at_q     <= out_at_d;
    out_cnt_q    <= out_cnt_d;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    hi_d         = hi_q;
    key_d        = key_q;
    pend_d       = pend_q;
    first_d      = first_q;
    tag_d        = tag_q;
    res_status_d = res_status_q;
    res_word_d   = res_word_q;
    res_at_d     = res_at_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_status_d = out_status_q;
    out_word_d   = out_word_q;
    out_at_d     = out_at_q;
    out_cnt_d    = out_cnt_q;
    mem_we       = 1'b0;
    mem_waddr    = tag_q;
    mem_wdata    = rdata_q;
    mem_raddr    = idx_q[iat_pkg::ADDR_W-1:0];

    unique case (state_q)
      iat_pkg::S_IDLE: begin
        if (in_acc) begin
          key_d        = in_i.word_in;
          pos_d        = in_pos;
          pend_d       = 1'b0;
          res_status_d = iat_pkg::STAT_OK;
          res_word_d   = '0;
          res_at_d     = '0;
          state_d      = iat_pkg::S_EMIT;
          unique case (iat_pkg::opcode_e'(in_i.opcode))
            iat_pkg::OP_INSERT_AT, iat_pkg::OP_PUSH_BACK: begin
              if (in_i.opcode == iat_pkg::OP_PUSH_BACK) begin
                pos_d = cnt_q;
              end
              if ((in_i.opcode == iat_pkg::OP_INSERT_AT) && (in_pos > cnt_q)) begin
                res_status_d = iat_pkg::STAT_RANGE;
              end else if (cnt_q == iat_pkg::CNT_W'(iat_pkg::CAPACITY)) begin
                res_status_d = iat_pkg::STAT_FULL;
              end else begin
                idx_d   = cnt_q;
                state_d = iat_pkg::S_SHIFT_UP;
              end
            end
            iat_pkg::OP_GET: begin
              if (in_pos >= cnt_q) begin
                res_status_d = iat_pkg::STAT_RANGE;
              end else begin
                state_d = iat_pkg::S_GET;
              end
            end
            iat_pkg::OP_REMOVE: begin
              if (in_pos >= cnt_q) begin
                res_status_d = iat_pkg::STAT_RANGE;
              end else begin
                idx_d   = in_pos;
                state_d = iat_pkg::S_SHIFT_DOWN;
              end
            end
            iat_pkg::OP_POP_BACK: begin
              if (cnt_q == '0) begin
                res_status_d = iat_pkg::STAT_RANGE;
              end else begin
                pos_d   = cnt_q - 1'b1;
                idx_d   = cnt_q - 1'b1;
                state_d = iat_pkg::S_SHIFT_DOWN;
              end
            end
            iat_pkg::OP_LINEAR_SEARCH: begin
              idx_d   = '0;
              state_d = iat_pkg::S_LINEAR;
            end
            iat_pkg::OP_BINARY_SEARCH: begin
              idx_d   = '0;
              hi_d    = cnt_q;
              state_d = iat_pkg::S_BIN_PROBE;
            end
            default: begin
              res_status_d = iat_pkg::STAT_OK;
            end
          endcase
        end
      end

      // move elements up from the top, read index-1 and write it to index in the following cycle
      iat_pkg::S_SHIFT_UP: begin
        mem_raddr = iat_pkg::ADDR_W'(idx_q - 1'b1);
        if (pend_q) begin
          mem_we = 1'b1;
        end
        if (idx_q > pos_q) begin
          pend_d = 1'b1;
          tag_d  = idx_q[iat_pkg::ADDR_W-1:0];
          idx_d  = idx_q - 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            mem_we    = 1'b1;
            mem_waddr = pos_q[iat_pkg::ADDR_W-1:0];
            mem_wdata = key_q;
            cnt_d     = cnt_q + 1'b1;
            state_d   = iat_pkg::S_EMIT;
          end
        end
      end

      // first read returns the removed word; later reads drop one place
      iat_pkg::S_SHIFT_DOWN: begin
        if (pend_q) begin
          if (first_q) begin
            res_word_d = rdata_q;
          end else begin
            mem_we = 1'b1;
          end
        end
        if (idx_q < cnt_q) begin
          pend_d  = 1'b1;
          first_d = (idx_q == pos_q);
          tag_d   = iat_pkg::ADDR_W'(idx_q - 1'b1);
          idx_d   = idx_q + 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            cnt_d   = cnt_q - 1'b1;
            state_d = iat_pkg::S_EMIT;
          end
        end
      end

      iat_pkg::S_GET: begin
        mem_raddr = pos_q[iat_pkg::ADDR_W-1:0];
        state_d   = iat_pkg::S_GET_WAIT;
      end

      iat_pkg::S_GET_WAIT: begin
        res_word_d = rdata_q;
        state_d    = iat_pkg::S_EMIT;
      end

      // compare the previous read while issuing the next one
      iat_pkg::S_LINEAR: begin
        if (pend_q && (rdata_q == key_q)) begin
          pend_d   = 1'b0;
          res_at_d = tag_q;
          state_d  = iat_pkg::S_EMIT;
        end else if (idx_q < cnt_q) begin
          pend_d = 1'b1;
          tag_d  = idx_q[iat_pkg::ADDR_W-1:0];
          idx_d  = idx_q + 1'b1;
        end else begin
          pend_d       = 1'b0;
          res_status_d = iat_pkg::STAT_MISS;
          state_d      = iat_pkg::S_EMIT;
        end
      end

      iat_pkg::S_BIN_PROBE: begin
        mem_raddr = mid[iat_pkg::ADDR_W-1:0];
        if (idx_q < hi_q) begin
          tag_d   = mid[iat_pkg::ADDR_W-1:0];
          state_d = iat_pkg::S_BIN_CMP;
        end else begin
          res_status_d = iat_pkg::STAT_MISS;
          state_d      = iat_pkg::S_EMIT;
        end
      end

      iat_pkg::S_BIN_CMP: begin
        if (key_q < rdata_q) begin
          hi_d    = iat_pkg::CNT_W'(tag_q);
          state_d = iat_pkg::S_BIN_PROBE;
        end else if (key_q == rdata_q) begin
          res_at_d = tag_q;
          state_d  = iat_pkg::S_EMIT;
        end else begin
          idx_d   = iat_pkg::CNT_W'(tag_q) + 1'b1;
          state_d = iat_pkg::S_BIN_PROBE;
        end
      end

      // hold the response until the output register is free
      iat_pkg::S_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_word_d   = res_word_q;
          out_at_d     = res_at_q;
          out_cnt_d    = cnt_q;
          state_d      = iat_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = iat_pkg::S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= iat_pkg::CNT_W'(iat_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iat_pkg::S_IDLE || state_q == iat_pkg::S_EMIT) |-> !mem_we)
    else $error("store written outside an operation");

  a_shift_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == iat_pkg::S_SHIFT_UP || state_q == iat_pkg::S_SHIFT_DOWN) && mem_we)
      |-> (mem_waddr != mem_raddr))
    else $error("shift reads the entry it writes");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q == iat_pkg::STAT_FULL)
      |-> (out_cnt_q == iat_pkg::CNT_W'(iat_pkg::CAPACITY)))
    else $error("store full reported below capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iat_pkg::S_IDLE) |=> (cnt_q == $past(cnt_q)))
    else $error("fill count changed while idle");
`endif

endmodule
